[design/ms_pkg.sv]
// ----------------------------------------------------------------------------
// ms_pkg
// Shared constants for the merge sorter: default set capacity and data width.
// ----------------------------------------------------------------------------
package ms_pkg;

    localparam int MS_DEPTH      = 64;
    localparam int MS_DATA_WIDTH = 32;

endpackage

[design/ms_mem.sv]
// ----------------------------------------------------------------------------
// ms_mem
// Synchronous RAM with one write port and two read ports, registered reads.
// ----------------------------------------------------------------------------
module ms_mem #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = 6
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]         i_raddr_a,
    input  logic [AW-1:0]         i_raddr_b,
    output logic [DATA_WIDTH-1:0] o_rdata_a,
    output logic [DATA_WIDTH-1:0] o_rdata_b
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata_a;
    logic [DATA_WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[design/merge_sorter.sv]
// Sequence: after the beat with i_last, ceil(log2(n)) merge passes, each opened by a
// pass-setup state, then a last setup state and the burst of n sorted results.
// Throughput: one item per cycle while loading; busy stays high from the last beat until
// the final result is issued, bound by the one write port of the destination memory.
// Reset: synchronous, active low; clears the count, overflow flag and strobe; no stall.
// ----------------------------------------------------------------------------
// merge_sorter
// Stable bottom-up merge sort over two ping-pong RAMs, with load and unload.
// ----------------------------------------------------------------------------
module merge_sorter
    import ms_pkg::*;
#(
    parameter int DEPTH      = MS_DEPTH,
    parameter int DATA_WIDTH = MS_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    input  logic                         i_last,
    output logic                         o_valid,
    output logic signed [DATA_WIDTH-1:0] o_sorted_value,
    output logic                         o_end_of_set,
    output logic                         o_overflow
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = CW + 1;
    localparam int XW = CW + 2;

    typedef logic [CW-1:0] t_cnt;
    typedef logic [WW-1:0] t_wid;
    typedef logic [XW-1:0] t_ext;
    typedef logic [DATA_WIDTH-1:0] t_data;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PSTART,
        ST_MERGE,
        ST_OUT
    } t_state;

    t_state r_state, n_state;
    t_cnt   r_cnt, n_cnt;
    logic   r_ovf, n_ovf;
    t_cnt   r_n, n_n;
    t_wid   r_w, n_w;
    logic   r_sel, n_sel;
    t_cnt   r_a, n_a;
    t_cnt   r_b, n_b;
    t_cnt   r_k, n_k;
    t_cnt   r_mid, n_mid;
    t_cnt   r_hi, n_hi;
    logic   r_o_valid, n_o_valid;
    t_data  r_o_value, n_o_value;
    logic   r_o_end, n_o_end;
    logic   r_o_ovf, n_o_ovf;

    t_data  rd0_a, rd0_b, rd1_a, rd1_b;
    t_data  src_a, src_b, merge_data;
    logic   a_has, b_has, take_a;
    logic   load_we, merge_we;
    logic   we0, we1;
    logic [AW-1:0] waddr0;
    t_data  wdata0;
    t_cnt   cnt_next;

    // Clamp a run boundary to the set size.
    function automatic t_cnt clip(input t_ext x, input t_cnt n);
        t_cnt res;
        res = (x > t_ext'(n)) ? n : x[CW-1:0];
        return res;
    endfunction

    assign src_a = r_sel ? rd1_a : rd0_a;
    assign src_b = r_sel ? rd1_b : rd0_b;

    // On a tie the element of the earlier run goes first, which keeps the sort stable.
    assign a_has      = (r_a < r_mid);
    assign b_has      = (r_b < r_hi);
    assign take_a     = a_has && (!b_has || ($signed(src_a) <= $signed(src_b)));
    assign merge_data = take_a ? src_a : src_b;

    assign load_we  = (r_state == ST_LOAD) && start && (r_cnt != t_cnt'(DEPTH));
    assign merge_we = (r_state == ST_MERGE);
    assign we0      = load_we || (merge_we && r_sel);
    assign we1      = merge_we && !r_sel;
    assign waddr0   = (r_state == ST_LOAD) ? r_cnt[AW-1:0] : r_k[AW-1:0];
    assign wdata0   = (r_state == ST_LOAD) ? i_value : merge_data;
    assign cnt_next = load_we ? (r_cnt + t_cnt'(1)) : r_cnt;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_ovf     = r_ovf;
        n_n       = r_n;
        n_w       = r_w;
        n_sel     = r_sel;
        n_a       = r_a;
        n_b       = r_b;
        n_k       = r_k;
        n_mid     = r_mid;
        n_hi      = r_hi;
        n_o_valid = 1'b0;
        n_o_value = r_o_value;
        n_o_end   = r_o_end;
        n_o_ovf   = r_o_ovf;

        case (r_state)
            ST_LOAD: begin
                if (start) begin
                    n_cnt = cnt_next;
                    if (!load_we) begin
                        n_ovf = 1'b1;
                    end
                    if (i_last) begin
                        n_n     = cnt_next;
                        n_w     = t_wid'(1);
                        n_sel   = 1'b0;
                        n_state = ST_PSTART;
                    end
                end
            end
            ST_PSTART: begin
                if (r_w >= t_wid'(r_n)) begin
                    n_a     = '0;
                    n_state = ST_OUT;
                end else begin
                    n_k     = '0;
                    n_a     = '0;
                    n_mid   = clip(t_ext'(r_w), r_n);
                    n_hi    = clip(t_ext'(r_w) << 1, r_n);
                    n_b     = n_mid;
                    n_state = ST_MERGE;
                end
            end
            ST_MERGE: begin
                n_k = r_k + t_cnt'(1);
                if (n_k == r_hi) begin
                    if (r_hi == r_n) begin
                        n_sel   = !r_sel;
                        n_w     = r_w << 1;
                        n_state = ST_PSTART;
                    end else begin
                        // Next pair of runs starts where this one ended.
                        n_a   = r_hi;
                        n_mid = clip(t_ext'(r_hi) + t_ext'(r_w), r_n);
                        n_hi  = clip(t_ext'(r_hi) + (t_ext'(r_w) << 1), r_n);
                        n_b   = n_mid;
                    end
                end else begin
                    n_a = r_a + t_cnt'(take_a);
                    n_b = r_b + t_cnt'(!take_a);
                end
            end
            ST_OUT: begin
                n_o_valid = 1'b1;
                n_o_value = src_a;
                n_o_end   = ((r_a + t_cnt'(1)) == r_n);
                n_o_ovf   = r_ovf;
                n_a       = r_a + t_cnt'(1);
                if (n_o_end) begin
                    n_cnt   = '0;
                    n_ovf   = 1'b0;
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_cnt     <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_ovf     <= n_ovf;
            r_o_valid <= n_o_valid;
        end
        r_n       <= n_n;
        r_w       <= n_w;
        r_sel     <= n_sel;
        r_a       <= n_a;
        r_b       <= n_b;
        r_k       <= n_k;
        r_mid     <= n_mid;
        r_hi      <= n_hi;
        r_o_value <= n_o_value;
        r_o_end   <= n_o_end;
        r_o_ovf   <= n_o_ovf;
    end

    // Both RAMs read at the next run heads, so the read data always matches r_a and r_b.
    ms_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_mem0 (
        .i_clk     (i_clk),
        .i_we      (we0),
        .i_waddr   (waddr0),
        .i_wdata   (wdata0),
        .i_raddr_a (n_a[AW-1:0]),
        .i_raddr_b (n_b[AW-1:0]),
        .o_rdata_a (rd0_a),
        .o_rdata_b (rd0_b)
    );

    ms_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_mem1 (
        .i_clk     (i_clk),
        .i_we      (we1),
        .i_waddr   (r_k[AW-1:0]),
        .i_wdata   (merge_data),
        .i_raddr_a (n_a[AW-1:0]),
        .i_raddr_b (n_b[AW-1:0]),
        .o_rdata_a (rd1_a),
        .o_rdata_b (rd1_b)
    );

    assign busy           = (r_state != ST_LOAD);
    assign o_valid        = r_o_valid;
    assign o_sorted_value = r_o_value;
    assign o_end_of_set   = r_o_end;
    assign o_overflow     = r_o_ovf;

endmodule

[design/ms_chk.sv]
// ----------------------------------------------------------------------------
// ms_chk
// Port-level checks for the merge sorter: result ordering, burst framing, a steady overflow flag and busy.
// ----------------------------------------------------------------------------
module ms_chk
    import ms_pkg::*;
#(
    parameter int DATA_WIDTH = MS_DATA_WIDTH
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  busy,
    input logic                  o_valid,
    input logic [DATA_WIDTH-1:0] o_sorted_value,
    input logic                  o_end_of_set,
    input logic                  o_overflow
);

    // Results of one set come out as an unbroken burst.
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_end_of_set |=> o_valid)
        else $error("result burst broken before end of set");

    // Each beat of a burst is not smaller than the one before it.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_end_of_set |=>
            $signed(o_sorted_value) >= $signed($past(o_sorted_value)))
        else $error("results not in ascending order");

    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_end_of_set |=> o_overflow == $past(o_overflow))
        else $error("overflow flag changed within a set");

    // The block is free again once the final beat is on the ports.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_set |-> !busy)
        else $error("busy still high with the final result");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_end_of_set |-> busy)
        else $error("busy low in the middle of a result burst");

endmodule

bind merge_sorter ms_chk #(
    .DATA_WIDTH (DATA_WIDTH)
) u_ms_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_sorted_value (o_sorted_value),
    .o_end_of_set   (o_end_of_set),
    .o_overflow     (o_overflow)
);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for merge_sorter. Sets of signed values are loaded one
// beat at a time. A behavioral sort of the same sets predicts the sorted
// results (typed in for directed single-element sets), and each strobed output is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import ms_pkg::*;

    localparam int W            = MS_DATA_WIDTH;
    localparam int D            = MS_DEPTH;
    localparam int TOTAL_BEATS  = 360;
    localparam int DRAIN_CYCLES = 600;
    localparam int N_ROWS       = 21;

    localparam logic signed [W-1:0] VAL_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VAL_MIN = {1'b1, {(W-1){1'b0}}};

    typedef struct {
        logic signed [W-1:0] value;
        logic                end_of_set;
        logic                overflow;
    } t_sorted_beat;

    typedef struct {
        logic signed [W-1:0] value;
        logic                last;
        bit                  typed;
        logic signed [W-1:0] typed_value;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic signed [W-1:0] i_value;
    logic                i_last;
    logic                o_valid;
    logic signed [W-1:0] o_sorted_value;
    logic                o_end_of_set;
    logic                o_overflow;

    t_sorted_beat        pending_sorted[$];
    t_sorted_beat        set_results[$];
    logic signed [W-1:0] held_elements[D];
    int                  held_count;
    bit                  held_overflow;
    int                  mismatch_count;
    int                  beats_sent;

    // Single-element sets come back unchanged, so their result is typed in.
    t_stim_row directed_rows [N_ROWS] = '{
        '{VAL_MAX,      1'b1, 1'b1, VAL_MAX},
        '{VAL_MIN,      1'b1, 1'b1, VAL_MIN},
        '{32'sd0,       1'b1, 1'b1, 32'sd0},
        '{-32'sd1,      1'b1, 1'b1, -32'sd1},
        '{32'sd5,       1'b0, 1'b0, 32'sd0},
        '{VAL_MIN,      1'b0, 1'b0, 32'sd0},
        '{32'sd5,       1'b0, 1'b0, 32'sd0},
        '{VAL_MAX,      1'b1, 1'b0, 32'sd0},
        '{32'sd100,     1'b0, 1'b0, 32'sd0},
        '{32'sd90,      1'b0, 1'b0, 32'sd0},
        '{-32'sd3,      1'b0, 1'b0, 32'sd0},
        '{-32'sd3,      1'b0, 1'b0, 32'sd0},
        '{-32'sd200,    1'b0, 1'b0, 32'sd0},
        '{VAL_MIN,      1'b1, 1'b0, 32'sd0},
        '{VAL_MAX,      1'b0, 1'b0, 32'sd0},
        '{VAL_MIN,      1'b1, 1'b0, 32'sd0},
        '{32'sd7,       1'b0, 1'b0, 32'sd0},
        '{32'sd7,       1'b0, 1'b0, 32'sd0},
        '{32'sd7,       1'b0, 1'b0, 32'sd0},
        '{32'sd7,       1'b0, 1'b0, 32'sd0},
        '{32'sd7,       1'b1, 1'b0, 32'sd0}
    };

    merge_sorter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .o_sorted_value (o_sorted_value),
        .o_end_of_set   (o_end_of_set),
        .o_overflow     (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("merge_sorter regression: fail");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_sorted_beat exp_beat;
        if (i_rst_n === 1'b1) begin
            if ($isunknown(o_valid)) begin
                report_mismatch("result strobe is unknown");
            end else if (o_valid) begin
                if (pending_sorted.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d", o_sorted_value));
                end else begin
                    exp_beat = pending_sorted.pop_front();
                    if (o_sorted_value !== exp_beat.value)
                        report_mismatch($sformatf("sorted_value got %0d exp %0d",
                                                  o_sorted_value, exp_beat.value));
                    if (o_end_of_set !== exp_beat.end_of_set)
                        report_mismatch($sformatf("end_of_set got %b exp %b",
                                                  o_end_of_set, exp_beat.end_of_set));
                    if (o_overflow !== exp_beat.overflow)
                        report_mismatch($sformatf("overflow got %b exp %b",
                                                  o_overflow, exp_beat.overflow));
                end
            end
        end
    end

    // Keeps the set as the block would, and on the last beat sorts it into
    // set_results. Equal values cannot be told apart, so a stable insertion
    // sort gives the same order as the merge passes.
    task automatic predict_sort_beat(input logic signed [W-1:0] v, input logic l);
        logic signed [W-1:0] key;
        int                  j;
        t_sorted_beat        r;
        set_results.delete();
        if (held_count < D) begin
            held_elements[held_count] = v;
            held_count++;
        end else begin
            held_overflow = 1'b1;
        end
        if (l) begin
            for (int i = 1; i < held_count; i++) begin
                key = held_elements[i];
                j = i - 1;
                while (j >= 0 && held_elements[j] > key) begin
                    held_elements[j+1] = held_elements[j];
                    j--;
                end
                held_elements[j+1] = key;
            end
            for (int k = 0; k < held_count; k++) begin
                r.value      = held_elements[k];
                r.end_of_set = (k == held_count - 1);
                r.overflow   = held_overflow;
                set_results.push_back(r);
            end
            held_count    = 0;
            held_overflow = 1'b0;
        end
    endtask

    task automatic send_beat(input logic signed [W-1:0] v, input logic l,
                             input bit typed, input logic signed [W-1:0] typed_value);
        t_sorted_beat r;
        bit           idle_ok;
        idle_ok = !(beats_sent >= 160 && beats_sent < 260);
        while (idle_ok && $urandom_range(0, 99) < 7) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_value <= v;
        i_last  <= l;
        do @(posedge i_clk); while (busy !== 1'b0);
        beats_sent++;
        predict_sort_beat(v, l);
        if (l) begin
            if (typed) begin
                r.value      = typed_value;
                r.end_of_set = 1'b1;
                r.overflow   = 1'b0;
                pending_sorted.push_back(r);
            end else begin
                foreach (set_results[k]) pending_sorted.push_back(set_results[k]);
            end
        end
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_sorted.size() != 0);
    endtask

    // Mix of extremes, a narrow band that forces ties, and full-range values.
    function automatic logic signed [W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            case ($urandom_range(0, 3))
                0: return VAL_MAX;
                1: return VAL_MIN;
                2: return '0;
                default: return '1;
            endcase
        end else if (sel <= 3) begin
            return $signed(W'($urandom_range(0, 8))) - 4;
        end
        return $signed(W'($urandom));
    endfunction

    task automatic send_set(input int size);
        for (int i = 0; i < size; i++)
            send_beat(pick_value(), i == size - 1, 1'b0, '0);
    endtask

    function automatic int pick_set_size();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) return $urandom_range(1, 8);
        if (sel < 80) return $urandom_range(9, D - 1);
        if (sel < 87) return D;
        if (sel < 94) return D + 1;
        return $urandom_range(D + 2, D + 6);
    endfunction

    initial begin
        int set_index;
        start          = 1'b0;
        i_value        = '0;
        i_last         = 1'b0;
        i_rst_n        = 1'b0;
        held_count     = 0;
        held_overflow  = 1'b0;
        mismatch_count = 0;
        beats_sent     = 0;
        set_index      = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n])
            send_beat(directed_rows[n].value, directed_rows[n].last,
                      directed_rows[n].typed, directed_rows[n].typed_value);
        wait_for_results();

        // A full store, a last beat that is dropped, and a longer overrun.
        send_set(D);
        send_set(D + 1);
        send_set(D + 3);
        while (beats_sent < TOTAL_BEATS) begin
            send_set(pick_set_size());
            set_index++;
            if (set_index % 6 == 0) wait_for_results();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("merge_sorter regression: pass");
        end else begin
            $display("merge_sorter regression: fail");
        end
        $finish;
    end

endmodule
